FILE: hdl/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg
// shared types and constants of the spectrum bar and peak hold meter
// ----------------------------------------------------------------------------
package spb_pkg;

    localparam int BANDS   = 16;
    localparam int BAND_W  = 4;
    localparam int LEVEL_W = 15;
    localparam int DECAY_W = 16;
    localparam int CFG_W   = 16;
    localparam int PROD_W  = LEVEL_W + DECAY_W;

    localparam logic [LEVEL_W-1:0] ONE_Q14   = 15'd16384;
    localparam logic [LEVEL_W-1:0] ZERO_Q14  = 15'd0;

    localparam logic [DECAY_W-1:0] BAR_DECAY_RST  = 16'd58982;
    localparam logic [DECAY_W-1:0] PEAK_DECAY_RST = 16'd63570;

    localparam logic CFG_BAR_DECAY  = 1'b0;
    localparam logic CFG_PEAK_DECAY = 1'b1;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [BAND_W-1:0]  band_index;
        logic signed [15:0] level;
    } item_word_t;

    typedef struct packed {
        logic [BAND_W-1:0]  band_out;
        logic [LEVEL_W-1:0] bar_level;
        logic [LEVEL_W-1:0] peak_level;
    } result_word_t;

    // level * decay in q0.16, truncated
    function automatic logic [LEVEL_W-1:0] scale_q16(
        input logic [LEVEL_W-1:0] lvl,
        input logic [DECAY_W-1:0] factor
    );
        logic [PROD_W-1:0] prod;
        begin
            prod = PROD_W'(lvl) * PROD_W'(factor);
            return prod[PROD_W-1:DECAY_W];
        end
    endfunction

    // clamp signed q2.14 level to 0..1.0
    function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [15:0] raw);
        begin
            if (raw[15])
                return ZERO_Q14;
            else if (raw[LEVEL_W-1:0] > ONE_Q14)
                return ONE_Q14;
            else
                return raw[LEVEL_W-1:0];
        end
    endfunction

endpackage

FILE: hdl/spb_in_if.sv
// ----------------------------------------------------------------------------
// spb_in_if
// valid/ready channel carrying one input word of the meter
// ----------------------------------------------------------------------------
interface spb_in_if;
    import spb_pkg::*;

    logic       valid;
    logic       ready;
    item_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/spb_out_if.sv
// ----------------------------------------------------------------------------
// spb_out_if
// valid/ready channel carrying one result word of the meter
// ----------------------------------------------------------------------------
interface spb_out_if;
    import spb_pkg::*;

    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/spectrum_bar_peak_hold_top.sv
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold_top
// peak hold level meter with decay, one bar and one peak per band
// ----------------------------------------------------------------------------
// usage
//   item   : input words {action, band_index, level}; update one band or
//            clear all bands
//   result : one word per input word {band_out, bar_level, peak_level}
//   cfg    : write-only port, index 0 = bar decay, index 1 = peak decay (q0.16)
// timing
//   a word taken from item sits in the input register; its band is read,
//   decayed and written back while the result register loads, so the
//   result is valid once the result register is free; one word per cycle
//   sustained while result is ready; the read-modify-write of the band store
//   and the two 15x16 multiplies fit between input and result register
// reset
//   all bars and peaks zero, decays at their default values, both
//   channels empty
// stall
//   with result held, the input register keeps its word and ready drops
//   only when both registers are full
// ----------------------------------------------------------------------------
module spectrum_bar_peak_hold_top (
    input  logic                         clk,
    input  logic                         rst_n,
    spb_in_if.sink                       item,
    spb_out_if.source                    result,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [spb_pkg::CFG_W-1:0]    cfg_data
);
    import spb_pkg::*;

    logic [DECAY_W-1:0] bar_decay_reg;
    logic [DECAY_W-1:0] peak_decay_reg;

    logic               s1_valid_reg;
    item_word_t         s1_word_reg;
    logic               out_valid_reg;
    result_word_t       out_word_reg;

    logic [LEVEL_W-1:0] bar_store_reg  [BANDS];
    logic [LEVEL_W-1:0] peak_store_reg [BANDS];

    logic               s1_advance;
    logic               take;
    logic [LEVEL_W-1:0] incoming;
    logic [LEVEL_W-1:0] cur_bar;
    logic [LEVEL_W-1:0] held;
    logic [LEVEL_W-1:0] bar_next;
    logic [LEVEL_W-1:0] peak_next;
    result_word_t       out_word_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_decay_reg  <= BAR_DECAY_RST;
            peak_decay_reg <= PEAK_DECAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BAR_DECAY:  bar_decay_reg  <= cfg_data[DECAY_W-1:0];
                CFG_PEAK_DECAY: peak_decay_reg <= cfg_data[DECAY_W-1:0];
                default:        ;
            endcase
        end
    end

    // handshake
    assign s1_advance   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready   = !s1_valid_reg || s1_advance;
    assign take         = item.valid && item.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

    // band update
    always_comb
    begin
        incoming = clamp_level(s1_word_reg.level);
        cur_bar  = bar_store_reg[s1_word_reg.band_index];
        held     = scale_q16(peak_store_reg[s1_word_reg.band_index], peak_decay_reg);
        if (incoming > cur_bar)
            bar_next = incoming;
        else
            bar_next = scale_q16(cur_bar, bar_decay_reg);
        peak_next = (bar_next > held) ? bar_next : held;

        out_word_next.band_out = s1_word_reg.band_index;
        if (s1_word_reg.action == ACT_CLEAR)
        begin
            out_word_next.bar_level  = ZERO_Q14;
            out_word_next.peak_level = ZERO_Q14;
        end
        else
        begin
            out_word_next.bar_level  = bar_next;
            out_word_next.peak_level = peak_next;
        end
    end

    // band store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BANDS; i++)
            begin
                bar_store_reg[i]  <= ZERO_Q14;
                peak_store_reg[i] <= ZERO_Q14;
            end
        end
        else if (s1_advance)
        begin
            if (s1_word_reg.action == ACT_CLEAR)
            begin
                for (int i = 0; i < BANDS; i++)
                begin
                    bar_store_reg[i]  <= ZERO_Q14;
                    peak_store_reg[i] <= ZERO_Q14;
                end
            end
            else
            begin
                bar_store_reg[s1_word_reg.band_index]  <= bar_next;
                peak_store_reg[s1_word_reg.band_index] <= peak_next;
            end
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                s1_valid_reg <= item.valid;
            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
            s1_word_reg <= item.data;
        if (s1_advance)
            out_word_reg <= out_word_next;
    end

    // checks
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_word_reg.action == ACT_CLEAR |=>
            out_word_reg.bar_level == ZERO_Q14 && out_word_reg.peak_level == ZERO_Q14)
        else $error("clear word did not give zero levels");

    a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_word_reg.bar_level <= ONE_Q14)
        else $error("bar level above full scale");

    a_peak_ge_bar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_word_reg.peak_level >= out_word_reg.bar_level)
        else $error("peak below bar");

    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> s1_valid_reg && out_valid_reg && !result.ready)
        else $error("input stalled while pipeline can move");

    a_cleared_store: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_word_reg.action == ACT_CLEAR |=>
            bar_store_reg[$past(s1_word_reg.band_index)] == ZERO_Q14)
        else $error("band store not cleared");

endmodule
